// ===== rtl/ehp_pkg.sv =====
// shared types and constants for the ethernet / ipv4 / l4 header parser
// no dependencies; imported by every rtl file of the block
package ehp_pkg;

  // frame length field width, wide enough for the largest supported frame size
  localparam int unsigned FRAME_LEN_W = 16;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  localparam logic [7:0]  ETH_HDR_BYTES  = 8'd14;
  localparam logic [7:0]  UDP_HDR_BYTES  = 8'd8;
  localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;
  localparam logic [10:0] LEN_MAX        = 11'd2047;

  localparam logic [1:0]  CLASS_TCP      = 2'd0;
  localparam logic [1:0]  CLASS_UDP      = 2'd1;
  localparam logic [1:0]  CLASS_ICMP     = 2'd2;
  localparam logic [1:0]  CLASS_OTHER    = 2'd3;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  frame_class;
    logic        dispatched;
    logic        truncated;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [10:0] payload_offset;
    logic [10:0] payload_len;
    logic [31:0] tcp_total;
    logic [31:0] udp_total;
  } out_item_t;

  // header fields of one finished frame, handed from front to back
  typedef struct packed {
    logic [FRAME_LEN_W-1:0] frame_len;
    logic                   is_ipv4;
    logic [3:0]             ip_header_words;
    logic [7:0]             ip_proto;
    logic [15:0]            src_port;
    logic [15:0]            dst_port;
    logic [3:0]             tcp_offset_words;
  } frame_summary_t;

endpackage

// ===== rtl/ethernet_ipv4_l4_header_parser.sv =====
// top level of the ethernet / ipv4 / tcp-udp header parser
// depends on ehp_pkg, ehp_front, ehp_queue, ehp_back
//
// usage:
//   in channel  (in_valid / in_ready / in_item): one frame byte per request,
//     last_byte set on the final byte of each frame
//   out channel (out_valid / out_ready / out_item): one descriptor per frame
//     (class, dispatch and truncation flags, ports, payload offset and length,
//     saturating tcp and udp frame totals after this frame)
// throughput: one byte per cycle unless the queue is full; the byte tracker
//   updates position and captured fields in the cycle the byte is taken
// descriptor path: the summary is written into the queue when the last byte
//   is accepted, then classified into the output register once that register
//   is empty or being taken by the receiver
// the two-entry summary queue lets bytes keep flowing while a descriptor
//   waits; in_ready drops only when both queue entries are occupied, which
//   needs the receiver to stall across several back-to-back frame ends
// bytes past MAX_FRAME_BYTES are accepted but neither counted nor captured
// reset: synchronous, clears position, captured fields, counters and queue;
//   no descriptor is pending afterwards
module ethernet_ipv4_l4_header_parser import ehp_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 2048
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic           take;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_not_empty;
  frame_summary_t push_summary;
  frame_summary_t head_summary;

  // byte requests are held off only while the summary queue is full
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  ehp_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .item    (in_item),
    .push    (push),
    .summary (push_summary)
  );

  ehp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_summary),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_summary)
  );

  ehp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_not_empty),
    .head       (head_summary),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

// ===== rtl/ehp_front.sv =====
// byte tracker: counts frame position and captures header fields
// depends on ehp_pkg; pushes one frame summary per last byte
module ehp_front import ehp_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 2048
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  in_item_t       item,
  output logic           push,
  output frame_summary_t summary
);

  localparam int unsigned PW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned CW = (PW > 8) ? PW : 8;

  logic [PW-1:0] position;
  logic [15:0]   ether_kind;
  logic [3:0]    ip_header_words;
  logic [7:0]    ip_proto;
  logic [15:0]   src_port_reg;
  logic [15:0]   dst_port_reg;
  logic [3:0]    tcp_offset_words;

  logic [PW-1:0] position_cap;
  logic [15:0]   ether_cap;
  logic [3:0]    ihl_cap;
  logic [7:0]    proto_cap;
  logic [15:0]   src_cap;
  logic [15:0]   dst_cap;
  logic [3:0]    toff_cap;

  logic [CW-1:0] pos_c;
  logic [CW-1:0] l4_start;
  logic          counting;

  assign pos_c    = CW'(position);
  assign l4_start = CW'(ETH_HDR_BYTES) + CW'({ip_header_words, 2'b00});
  assign counting = position < PW'(MAX_FRAME_BYTES);

  always_comb begin
    position_cap = position;
    ether_cap    = ether_kind;
    ihl_cap      = ip_header_words;
    proto_cap    = ip_proto;
    src_cap      = src_port_reg;
    dst_cap      = dst_port_reg;
    toff_cap     = tcp_offset_words;
    if (counting) begin
      position_cap = position + PW'(1);
      if (pos_c == CW'(12)) ether_cap[15:8] = item.frame_byte;
      if (pos_c == CW'(13)) ether_cap[7:0]  = item.frame_byte;
      if (pos_c == CW'(14)) ihl_cap         = item.frame_byte[3:0];
      if (pos_c == CW'(23)) proto_cap       = item.frame_byte;
      // l4 fields only once a plausible ihl is known
      if (ip_header_words >= MIN_HDR_WORDS) begin
        if (pos_c == l4_start)               src_cap[15:8] = item.frame_byte;
        if (pos_c == l4_start + CW'(1))      src_cap[7:0]  = item.frame_byte;
        if (pos_c == l4_start + CW'(2))      dst_cap[15:8] = item.frame_byte;
        if (pos_c == l4_start + CW'(3))      dst_cap[7:0]  = item.frame_byte;
        if (pos_c == l4_start + CW'(12))     toff_cap      = item.frame_byte[7:4];
      end
    end
  end

  assign push = take && item.last_byte;

  always_comb begin
    summary.frame_len        = FRAME_LEN_W'(position_cap);
    summary.is_ipv4          = (ether_cap == ETHERTYPE_IPV4);
    summary.ip_header_words  = ihl_cap;
    summary.ip_proto         = proto_cap;
    summary.src_port         = src_cap;
    summary.dst_port         = dst_cap;
    summary.tcp_offset_words = toff_cap;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      position         <= '0;
      ether_kind       <= '0;
      ip_header_words  <= '0;
      ip_proto         <= '0;
      src_port_reg     <= '0;
      dst_port_reg     <= '0;
      tcp_offset_words <= '0;
    end else if (take) begin
      position         <= position_cap;
      ether_kind       <= ether_cap;
      ip_header_words  <= ihl_cap;
      ip_proto         <= proto_cap;
      src_port_reg     <= src_cap;
      dst_port_reg     <= dst_cap;
      tcp_offset_words <= toff_cap;
    end
  end

endmodule

// ===== rtl/ehp_queue.sv =====
// two-entry queue of frame summaries between the byte tracker and the classifier
// depends on ehp_pkg
module ehp_queue import ehp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  frame_summary_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output frame_summary_t head
);

  frame_summary_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(push) && !$past(pop) |-> count == $past(count) + 2'd1)
    else $error("queue count did not advance on push");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push || pop)
    else $error("queue written while full");

endmodule

// ===== rtl/ehp_back.sv =====
// classifier: turns a frame summary into a descriptor, keeps l4 frame counters
// depends on ehp_pkg; output register decouples the receiver
module ehp_back import ehp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  frame_summary_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output out_item_t      out_item
);

  logic [31:0] tcp_counter;
  logic [31:0] udp_counter;
  logic [31:0] tcp_counter_next;
  logic [31:0] udp_counter_next;

  logic [FRAME_LEN_W-1:0] len;
  logic [7:0]             l4_start;
  logic [7:0]             hdr_end;
  logic [FRAME_LEN_W-1:0] hdr_end_w;
  logic [FRAME_LEN_W-1:0] plen_full;
  logic [10:0]            plen_sat;
  out_item_t              desc;

  assign len       = head.frame_len;
  assign l4_start  = ETH_HDR_BYTES + {2'b00, head.ip_header_words, 2'b00};
  assign hdr_end   = (head.ip_proto == PROTO_TCP)
                   ? l4_start + {2'b00, head.tcp_offset_words, 2'b00}
                   : l4_start + UDP_HDR_BYTES;
  assign hdr_end_w = FRAME_LEN_W'(hdr_end);
  assign plen_full = len - hdr_end_w;
  assign plen_sat  = (plen_full > FRAME_LEN_W'(LEN_MAX)) ? LEN_MAX : plen_full[10:0];

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    desc               = '0;
    desc.frame_class   = CLASS_OTHER;
    tcp_counter_next   = tcp_counter;
    udp_counter_next   = udp_counter;
    priority if (len < FRAME_LEN_W'(ETH_HDR_BYTES)) begin
      desc.truncated = 1'b1;
    end else if (!head.is_ipv4) begin
      desc.truncated = 1'b0;
    end else if (head.ip_header_words < MIN_HDR_WORDS ||
                 len < FRAME_LEN_W'(l4_start)) begin
      desc.truncated = 1'b1;
    end else if (head.ip_proto == PROTO_TCP || head.ip_proto == PROTO_UDP) begin
      if (head.ip_proto == PROTO_TCP) begin
        desc.frame_class = CLASS_TCP;
        tcp_counter_next = (&tcp_counter) ? tcp_counter : tcp_counter + 32'd1;
      end else begin
        desc.frame_class = CLASS_UDP;
        udp_counter_next = (&udp_counter) ? udp_counter : udp_counter + 32'd1;
      end
      priority if ((head.ip_proto == PROTO_TCP &&
                    head.tcp_offset_words < MIN_HDR_WORDS) || len < hdr_end_w) begin
        desc.truncated = 1'b1;
      end else if (len > hdr_end_w) begin
        desc.dispatched     = 1'b1;
        desc.source_port    = head.src_port;
        desc.dest_port      = head.dst_port;
        desc.payload_offset = {3'b000, hdr_end};
        desc.payload_len    = plen_sat;
      end else begin
        // headers only, nothing to hand on
        desc.dispatched = 1'b0;
      end
    end else if (head.ip_proto == PROTO_ICMP) begin
      desc.frame_class    = CLASS_ICMP;
      desc.dispatched     = 1'b1;
      desc.payload_offset = {3'b000, l4_start};
    end else begin
      desc.truncated = 1'b0;
    end
    desc.tcp_total = tcp_counter_next;
    desc.udp_total = udp_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      tcp_counter <= '0;
      udp_counter <= '0;
    end else begin
      if (pop) begin
        out_valid   <= 1'b1;
        tcp_counter <= tcp_counter_next;
        udp_counter <= udp_counter_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= desc;
    end
  end

  a_tcp_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> tcp_counter >= $past(tcp_counter))
    else $error("tcp counter went backwards");

  a_disp_not_trunc: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.dispatched |-> !out_item.truncated)
    else $error("truncated frame dispatched");

  a_l4_disp_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.dispatched && out_item.frame_class != CLASS_ICMP
      |-> out_item.payload_len != 11'd0)
    else $error("l4 frame dispatched with empty payload");

endmodule
